FILE: src/bfba_pkg.sv
// Shared constants and helper functions for the best-fit block allocator.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package bfba_pkg;

  // Default sizing of the block table.
  localparam int NUM_BLOCKS_DEF = 8;
  localparam int SIZE_BITS_DEF  = 20;

  // Fixed widths of the request and result ports.
  localparam int SIZE_PORT_W  = 20;
  localparam int INDEX_PORT_W = 3;
  localparam int CFG_W        = 4;

  // Value of blocks_in_use after reset.
  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

  // Operation codes on the op port.
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  // Bits needed to address a table of n entries (at least one).
  function automatic int idx_width(input int n);
    idx_width = (n > 1) ? $clog2(n) : 1;
  endfunction

  // Bits needed to count from zero up to n inclusive.
  function automatic int cnt_width(input int n);
    cnt_width = $clog2(n + 1);
  endfunction

endpackage

FILE: src/bfba_table.sv
// Block table: capacity and usage memories with per-entry valid bits.
// Depends on bfba_pkg for the address width function.
`timescale 1ns / 1ps

module bfba_table #(
  parameter int NUM_BLOCKS = bfba_pkg::NUM_BLOCKS_DEF,
  parameter int SIZE_BITS  = bfba_pkg::SIZE_BITS_DEF
) (
  input  logic                                           clk,
  input  logic                                           rst,
  input  logic                                           load_en,
  input  logic [bfba_pkg::idx_width(NUM_BLOCKS)-1:0]     load_addr,
  input  logic [SIZE_BITS-1:0]                           load_cap,
  input  logic                                           upd_en,
  input  logic [bfba_pkg::idx_width(NUM_BLOCKS)-1:0]     upd_addr,
  input  logic [SIZE_BITS-1:0]                           upd_used,
  input  logic                                           clear_used,
  input  logic [bfba_pkg::idx_width(NUM_BLOCKS)-1:0]     rd_addr,
  output logic [SIZE_BITS-1:0]                           rd_cap,
  output logic [SIZE_BITS-1:0]                           rd_used
);
  import bfba_pkg::*;

  logic [SIZE_BITS-1:0]  cap_mem  [NUM_BLOCKS];
  logic [SIZE_BITS-1:0]  used_mem [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0] cap_valid;
  logic [NUM_BLOCKS-1:0] used_valid;
  logic [SIZE_BITS-1:0]  rd_cap_q;
  logic [SIZE_BITS-1:0]  rd_used_q;
  logic                  rd_cap_ok;
  logic                  rd_used_ok;

  // Valid bits stand in for the all-zero reset of both arrays. A batch
  // clear wins over the usage write of the same request.
  always_ff @(posedge clk) begin
    if (rst) begin
      cap_valid  <= '0;
      used_valid <= '0;
    end else begin
      if (load_en) begin
        cap_valid[load_addr]  <= 1'b1;
        used_valid[load_addr] <= 1'b0;
      end else if (clear_used) begin
        used_valid <= '0;
      end else if (upd_en) begin
        used_valid[upd_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      cap_mem[load_addr] <= load_cap;
    end
    if (upd_en) begin
      used_mem[upd_addr] <= upd_used;
    end
    rd_cap_q   <= cap_mem[rd_addr];
    rd_used_q  <= used_mem[rd_addr];
    rd_cap_ok  <= cap_valid[rd_addr];
    rd_used_ok <= used_valid[rd_addr];
  end

  assign rd_cap  = rd_cap_ok  ? rd_cap_q  : '0;
  assign rd_used = rd_used_ok ? rd_used_q : '0;

endmodule

FILE: src/bfba_scan.sv
// Shared compare unit: judges one block per cycle and keeps the best fit so far.
// Depends on bfba_pkg for the index width function.
`timescale 1ns / 1ps

module bfba_scan #(
  parameter int NUM_BLOCKS = bfba_pkg::NUM_BLOCKS_DEF,
  parameter int SIZE_BITS  = bfba_pkg::SIZE_BITS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       clear,
  input  logic                                       valid,
  input  logic [bfba_pkg::idx_width(NUM_BLOCKS)-1:0] idx,
  input  logic [SIZE_BITS-1:0]                       cap,
  input  logic [SIZE_BITS-1:0]                       used,
  input  logic [SIZE_BITS-1:0]                       size,
  output logic                                       found,
  output logic [bfba_pkg::idx_width(NUM_BLOCKS)-1:0] best,
  output logic [SIZE_BITS-1:0]                       best_used
);
  import bfba_pkg::*;

  logic [SIZE_BITS-1:0] rem;
  logic [SIZE_BITS-1:0] best_rem;
  logic                 take;

  // A block that is overused never fits; ties keep the earlier block.
  assign rem  = cap - used;
  assign take = valid && (used <= cap) && (rem >= size) && (!found || (rem < best_rem));

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (clear) begin
      found <= 1'b0;
    end else if (take) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best      <= idx;
      best_rem  <= rem;
      best_used <= used;
    end
  end

endmodule

FILE: src/best_fit_block_allocator.sv
// Top level of the best-fit block allocator: sequencer, config register, outputs.
// Depends on bfba_pkg, bfba_table and bfba_scan.
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low. A load (op = 0)
// writes one block's capacity and clears its usage at that same edge; it
// produces no result and leaves busy low, so another request may follow at
// once. An allocation request (op = 1) walks the usable blocks one per cycle
// through a single subtract-and-compare unit fed from the block memories.
// With N usable blocks (blocks_in_use, capped at NUM_BLOCKS) the scan reads
// each of the N blocks once before the result, and none when no block is
// usable. busy is high from the cycle after acceptance through the result
// cycle, so the next request can be taken in the cycle after the result.
// The result appears on granted and block_number for exactly one cycle,
// marked by done; the receiver cannot stall it, so it must sample it then.
// block_number is zero when a request is not granted. A request flagged
// last_in_batch clears the usage of every block once it is served.
// blocks_in_use is written through cfg_we and cfg_data and should only be
// changed while busy is low; values above NUM_BLOCKS act as NUM_BLOCKS.
module best_fit_block_allocator #(
  parameter int NUM_BLOCKS = bfba_pkg::NUM_BLOCKS_DEF,
  parameter int SIZE_BITS  = bfba_pkg::SIZE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                op,
  input  logic [bfba_pkg::INDEX_PORT_W-1:0]   block_index,
  input  logic [bfba_pkg::SIZE_PORT_W-1:0]    size_value,
  input  logic                                last_in_batch,
  input  logic                                cfg_we,
  input  logic [bfba_pkg::CFG_W-1:0]          cfg_data,
  output logic                                done,
  output logic                                granted,
  output logic [bfba_pkg::INDEX_PORT_W-1:0]   block_number
);
  import bfba_pkg::*;

  localparam int IDX_W = idx_width(NUM_BLOCKS);
  localparam int CNT_W = cnt_width(NUM_BLOCKS);

  // Sequencer states.
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0]           state;
  logic [1:0]           state_next;
  logic [CFG_W-1:0]     blocks_in_use;
  logic [CNT_W-1:0]     cnt;
  logic                 pend;
  logic [IDX_W-1:0]     rd_idx;
  logic [SIZE_BITS-1:0] size_q;
  logic                 last_q;

  logic                 accept;
  logic                 load_go;
  logic                 req_go;
  logic [SIZE_BITS-1:0] size_in;
  logic [CNT_W-1:0]     limit;
  logic                 issue;

  logic [SIZE_BITS-1:0] rd_cap;
  logic [SIZE_BITS-1:0] rd_used;
  logic                 found;
  logic [IDX_W-1:0]     best;
  logic [SIZE_BITS-1:0] best_used;
  logic                 finishing;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  // A load whose index lies past the table is dropped.
  assign load_go = accept && (op == OP_LOAD) && (int'(block_index) < NUM_BLOCKS);
  assign req_go  = accept && (op == OP_REQUEST);

  // Sizes are kept modulo 2^SIZE_BITS.
  assign size_in = SIZE_BITS'({{SIZE_BITS{1'b0}}, size_value});

  // Number of blocks a request may look at.
  always_comb begin
    if (int'(blocks_in_use) > NUM_BLOCKS) begin
      limit = CNT_W'(NUM_BLOCKS);
    end else begin
      limit = CNT_W'(blocks_in_use);
    end
  end

  assign issue     = (state == S_SCAN) && (cnt < limit);
  assign finishing = (state == S_FINISH);

  always_ff @(posedge clk) begin
    if (rst) begin
      blocks_in_use <= CFG_RESET;
    end else if (cfg_we) begin
      blocks_in_use <= cfg_data;
    end
  end

  // The scan issues one read per cycle; the memory answers in the next cycle,
  // tracked by pend and rd_idx, and the compare unit takes it then. The scan
  // ends once every block is issued and the last answer has been compared.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_go) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!issue && !pend) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      if (req_go) begin
        cnt  <= '0;
        pend <= 1'b0;
      end else if (state == S_SCAN) begin
        pend <= issue;
        if (issue) begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_go) begin
      size_q <= size_in;
      last_q <= last_in_batch;
    end
    if (issue) begin
      rd_idx <= cnt[IDX_W-1:0];
    end
  end

  bfba_table #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_table (
    .clk        (clk),
    .rst        (rst),
    .load_en    (load_go),
    .load_addr  (IDX_W'({{IDX_W{1'b0}}, block_index})),
    .load_cap   (size_in),
    .upd_en     (finishing && found),
    .upd_addr   (best),
    .upd_used   (best_used + size_q),
    .clear_used (finishing && last_q),
    .rd_addr    (cnt[IDX_W-1:0]),
    .rd_cap     (rd_cap),
    .rd_used    (rd_used)
  );

  bfba_scan #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .clear     (req_go),
    .valid     (pend),
    .idx       (rd_idx),
    .cap       (rd_cap),
    .used      (rd_used),
    .size      (size_q),
    .found     (found),
    .best      (best),
    .best_used (best_used)
  );

  // The result is shown during the single finishing cycle.
  assign done         = finishing;
  assign granted      = finishing && found;
  assign block_number = (finishing && found)
                      ? INDEX_PORT_W'({{INDEX_PORT_W{1'b0}}, best}) : '0;

endmodule
